>>> hdl/swm_pkg.sv
`default_nettype none

package swm_pkg;

    // Store depth and sample width
    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int POS_BITS     = 32;

    // Window register field and effective window (holds 1..WINDOW_DEPTH)
    localparam int WSIZE_BITS = 7;
    localparam int WIN_BITS   = $clog2(WINDOW_DEPTH) + 1;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_WINDOW_SIZE = 1'b0;   // register select, paddr[2]
    localparam logic [WSIZE_BITS-1:0] WINDOW_SIZE_RESET = WSIZE_BITS'(1);

    // Stream payload widths
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((SAMPLE_BITS + POS_BITS + 7) / 8) * 8;

    // One candidate of the monotonic store
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [POS_BITS-1:0]           pos;
    } cand_t;

    // Broadcast control for the cell row
    typedef struct packed {
        logic accept;      // a word enters this cycle
        logic drop_head;   // head leaves the window on this word
        logic trim;        // shift one place toward the head, no word
        logic clear;       // end of sequence: empty the row
    } cell_ctrl_t;

    // Clamp the window register to 1..WINDOW_DEPTH
    function automatic logic [WIN_BITS-1:0] eff_window(input logic [WSIZE_BITS-1:0] wsize);
        logic [WIN_BITS-1:0] w;
        if (wsize == '0) begin
            w = WIN_BITS'(1);
        end else if (int'(wsize) > WINDOW_DEPTH) begin
            w = WIN_BITS'(WINDOW_DEPTH);
        end else begin
            w = WIN_BITS'(wsize);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/swm_cell.sv
`default_nettype none

module swm_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire swm_pkg::cell_ctrl_t ctrl,
    input  wire swm_pkg::cand_t      sample,     // incoming word as a candidate
    input  wire swm_pkg::cand_t      nbr_entry,  // cell one place toward the tail
    input  wire logic                nbr_kept,
    input  wire logic                left_kept,  // cell one place toward the head
    output swm_pkg::cand_t           entry,
    output logic                     kept
);
    import swm_pkg::*;

    cand_t entry_reg;
    cand_t entry_next;

    // Survives the tail sweep unless the new word is strictly larger
    assign kept  = entry_reg.valid && !($signed(sample.value) > $signed(entry_reg.value));
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.clear) begin
            entry_next.valid = 1'b0;
        end else if (ctrl.trim) begin
            entry_next = nbr_entry;
        end else if (ctrl.accept) begin
            if (ctrl.drop_head) begin
                if (nbr_kept) begin
                    entry_next = nbr_entry;
                end else if (kept) begin
                    entry_next = sample;
                end else begin
                    entry_next.valid = 1'b0;
                end
            end else begin
                if (kept) begin
                    entry_next = entry_reg;
                end else if (left_kept) begin
                    entry_next = sample;
                end else begin
                    entry_next.valid = 1'b0;
                end
            end
        end
    end

    // Only the valid bit is reset; value and position follow unconditionally
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.value <= entry_next.value;
        entry_reg.pos   <= entry_next.pos;
    end

endmodule

`default_nettype wire

>>> hdl/swm_cfg_regs.sv
`default_nettype none

module swm_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [swm_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [swm_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [swm_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                     pready,
    output logic [swm_pkg::WSIZE_BITS-1:0]           window_size
);
    import swm_pkg::*;

    logic [WSIZE_BITS-1:0] window_size_reg;
    logic                  wr_window;

    assign pready    = 1'b1;
    assign wr_window = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end else if (wr_window) begin
            window_size_reg <= pwdata[WSIZE_BITS-1:0];
        end
    end

    // Read back the raw register; other addresses read zero
    always_comb begin
        if (paddr[2] == REG_WINDOW_SIZE) begin
            prdata = APB_DATA_BITS'(window_size_reg);
        end else begin
            prdata = '0;
        end
    end

    assign window_size = window_size_reg;

endmodule

`default_nettype wire

>>> hdl/sliding_window_maximum_unit.sv
// Channel  | Ports                       | Word layout (low bit first)
// ---------+-----------------------------+--------------------------------------------
// s_ in    | s_tvalid s_tready s_tdata   | tdata[15:0] sample_value; tlast last_sample
// m_ out   | m_tvalid m_tready m_tdata   | tdata[15:0] window_max,
//          |                             | tdata[47:16] max_position; tlast last_result
// cfg      | APB psel..prdata            | 0x0 window_size[6:0], reset 1
//
// Cycles: one sample word per cycle in steady state; the result appears in the cycle
// after its sample is taken, from a single output register.
// After the window is shrunk mid-sequence, the row drops one aged head per cycle
// while the next sample waits with s_tready held low.
// Reset: synchronous, active low; empties the row, zeroes position and count.
// Stalls: s_tready drops while the output register holds a word that m_tready
// does not take this cycle, and while aged heads are dropped after a shrink.
`default_nettype none

module sliding_window_maximum_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [swm_pkg::S_TDATA_BITS-1:0]    s_tdata,   // [15:0] sample_value
    input  wire logic                                s_tlast,   // last_sample
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [swm_pkg::M_TDATA_BITS-1:0]         m_tdata,   // [15:0] window_max,
                                                                // [47:16] max_position
    output logic                                     m_tlast,   // last_result
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [swm_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [swm_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [swm_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                     pready
);
    import swm_pkg::*;

    logic [WSIZE_BITS-1:0] window_size;
    logic [WIN_BITS-1:0]   win;
    logic [POS_BITS-1:0]   win_wide;

    logic [POS_BITS-1:0]   next_pos_reg, next_pos_next;
    logic [WIN_BITS-1:0]   seen_reg, seen_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    cand_t                 sample;
    cell_ctrl_t            ctrl;
    cand_t                 cells     [WINDOW_DEPTH];
    logic                  kept      [WINDOW_DEPTH];
    cand_t                 nbr_entry [WINDOW_DEPTH];
    logic                  nbr_kept  [WINDOW_DEPTH];
    logic                  left_kept [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] valid_vec;

    logic                  s_acc;
    logic                  head_aged;
    logic                  second_aged;
    logic                  produce;
    cand_t                 head_next;

    swm_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .window_size (window_size)
    );

    assign win      = eff_window(window_size);
    assign win_wide = POS_BITS'(win);

    // New word as a candidate at the current sequence position
    assign sample.valid = 1'b1;
    assign sample.value = s_tdata[SAMPLE_BITS-1:0];
    assign sample.pos   = next_pos_reg;

    // Ages wrap modulo 2^POS_BITS. The head may be one window old on a new word;
    // the second cell being that old only follows a window shrink.
    assign head_aged   = kept[0] && ((next_pos_reg - cells[0].pos) >= win_wide);
    assign second_aged = cells[1].valid && ((next_pos_reg - cells[1].pos) >= win_wide);

    assign s_tready = !second_aged && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    // Drop aged heads only while a word waits, so the window in force when that
    // word is taken decides what leaves
    assign ctrl.accept    = s_acc;
    assign ctrl.drop_head = head_aged;
    assign ctrl.trim      = s_tvalid && second_aged;
    assign ctrl.clear     = s_acc && s_tlast;

    // Wire up neighbors: tail end sees an empty cell, head end sees a kept one
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (i == WINDOW_DEPTH - 1) begin
                nbr_entry[i] = '0;
                nbr_kept[i]  = 1'b0;
            end else begin
                nbr_entry[i] = cells[i+1];
                nbr_kept[i]  = kept[i+1];
            end
            if (i == 0) begin
                left_kept[i] = 1'b1;
            end else begin
                left_kept[i] = kept[i-1];
            end
            valid_vec[i] = cells[i].valid;
        end
    end

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        swm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .sample    (sample),
            .nbr_entry (nbr_entry[g]),
            .nbr_kept  (nbr_kept[g]),
            .left_kept (left_kept[g]),
            .entry     (cells[g]),
            .kept      (kept[g])
        );
    end

    // Head of the row after this word: the window maximum
    always_comb begin
        if (head_aged) begin
            head_next = kept[1] ? cells[1] : sample;
        end else begin
            head_next = kept[0] ? cells[0] : sample;
        end
    end

    // Count samples of the sequence, saturating at the window
    always_comb begin
        seen_next     = seen_reg;
        next_pos_next = next_pos_reg;
        if (s_acc) begin
            if (seen_reg < win) begin
                seen_next = seen_reg + WIN_BITS'(1);
            end
            next_pos_next = next_pos_reg + POS_BITS'(1);
            if (s_tlast) begin
                seen_next     = '0;
                next_pos_next = '0;
            end
        end
    end

    assign produce = s_acc && ((seen_reg < win ? seen_reg + WIN_BITS'(1) : seen_reg) >= win);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            next_pos_reg <= '0;
        end else begin
            seen_reg     <= seen_next;
            next_pos_reg <= next_pos_next;
        end
    end

    // Output register: load on a result, drop when taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (produce) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            m_tdata_reg <= M_TDATA_BITS'({head_next.pos, head_next.value});
            m_tlast_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // Valid cells always form a prefix from the head
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_vec} + {{WINDOW_DEPTH{1'b0}}, 1'b1}))
        else $error("candidate row has a hole");

    // Values never increase from the head to the second cell
    a_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        cells[1].valid |-> ($signed(cells[0].value) >= $signed(cells[1].value)))
        else $error("candidate row not monotonic");

    // A taken mid-sequence word leaves a nonempty row
    a_head_after_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tlast) |=> cells[0].valid)
        else $error("row empty after a sample");

    // End of sequence empties the row and restarts the position
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (!cells[0].valid && next_pos_reg == '0 && seen_reg == '0))
        else $error("sequence state not cleared");
`endif

endmodule

`default_nettype wire
